>>> sv/cms_pkg.sv
package cms_pkg;

  // sketch geometry
  localparam int Rows     = 4;
  localparam int Columns  = 1024;
  localparam int ColW     = $clog2(Columns);
  localparam int NumSeeds = 4;

  // field widths
  localparam int KeyW     = 64;
  localparam int CntW     = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  typedef logic [ColW-1:0]        col_t;
  typedef logic [KeyW-1:0]        key_t;
  typedef logic signed [CntW-1:0] cnt_t;

  // operation codes of an input item
  typedef enum logic {
    FUNC_ADD   = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEED_ROW0 = 3'd0,
    CFG_SEED_ROW1 = 3'd1,
    CFG_SEED_ROW2 = 3'd2,
    CFG_SEED_ROW3 = 3'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_e;

  // control of one counter bank
  typedef struct packed {
    logic rd_en;
    col_t rd_col;
    logic wr_en;
    col_t wr_col;
    logic clear;
    cnt_t amount;
  } bank_req_t;

endpackage

>>> sv/cms_in_if.sv
interface cms_in_if;
  import cms_pkg::*;

  logic valid;
  logic ready;
  logic func;
  key_t key;
  cnt_t amount;

  modport source (output valid, output func, output key, output amount, input ready);
  modport sink   (input valid, input func, input key, input amount, output ready);
endinterface

>>> sv/cms_out_if.sv
interface cms_out_if;
  import cms_pkg::*;

  logic valid;
  logic ready;
  cnt_t estimate;

  modport source (output valid, output estimate, input ready);
  modport sink   (input valid, input estimate, output ready);
endinterface

>>> sv/count_min_sketch_core.sv
// a query estimate passes the bank read register, then the estimate register, and
//   waits while an earlier estimate is not taken; a new item is accepted only when
//   idle, after the read-then-write-back on each bank's single read and write port
// reset: seeds clear to zero, then a clearing pass zeroes all 1024 columns of each
//   bank (all rows in parallel) before the first item is accepted
module count_min_sketch_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cms_in_if.sink                        in_i,
  cms_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [cms_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cms_pkg::CfgDataW-1:0]  cfg_data_i
);
  import cms_pkg::*;

  state_e    state_q, state_d;
  col_t      clr_addr_q;
  logic      func_q;
  key_t      key_q;
  cnt_t      amount_q;
  key_t      seed_q [NumSeeds];
  logic      out_valid_q;
  cnt_t      estimate_q;

  bank_req_t bank_req [Rows];
  cnt_t      bank_rd  [Rows];
  logic      accept;
  logic      out_load;
  logic      upd_done;
  cnt_t      best;

  // counter banks, one per row
  for (genvar r = 0; r < Rows; r++) begin : g_bank
    cms_bank u_bank (
      .clk_i     (clk_i),
      .req_i     (bank_req[r]),
      .rd_data_o (bank_rd[r])
    );
  end

  // minimum across rows
  always_comb begin
    best = {1'b0, {(CntW-1){1'b1}}};
    for (int r = 0; r < Rows; r++) begin
      if (bank_rd[r] < best) begin
        best = bank_rd[r];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == col_t'(Columns - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs and bank control
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    accept     = in_i.valid && in_i.ready;
    out_load   = (state_q == ST_UPDATE) && (func_q == FUNC_QUERY) &&
                 (!out_valid_q || out_o.ready);
    upd_done   = (func_q == FUNC_ADD) || out_load;
    for (int r = 0; r < Rows; r++) begin
      bank_req[r].rd_en  = accept;
      bank_req[r].rd_col = col_t'(in_i.key ^ seed_q[r]);
      bank_req[r].clear  = (state_q == ST_CLEAR);
      bank_req[r].amount = amount_q;
      bank_req[r].wr_en  = 1'b0;
      bank_req[r].wr_col = col_t'(key_q ^ seed_q[r]);
      unique case (state_q)
        ST_CLEAR: begin
          bank_req[r].wr_en  = 1'b1;
          bank_req[r].wr_col = clr_addr_q;
        end
        ST_UPDATE: begin
          bank_req[r].wr_en = (func_q == FUNC_ADD);
        end
        default: bank_req[r].wr_en = 1'b0;
      endcase
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.estimate = estimate_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + col_t'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // seed registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumSeeds; r++) begin
        seed_q[r] <= '0;
      end
    end else begin
      for (int r = 0; r < NumSeeds; r++) begin
        if (cfg_we_i && cfg_idx_i == CfgIdxW'(int'(CFG_SEED_ROW0) + r)) begin
          seed_q[r] <= cfg_data_i;
        end
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= in_i.func;
      key_q    <= in_i.key;
      amount_q <= in_i.amount;
    end
    if (out_load) begin
      estimate_q <= best;
    end
  end

  // no item taken while the banks are being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !in_i.ready)
    else $error("item accepted during clearing pass");

  // an accepted item moves straight to the update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == ST_UPDATE)
    else $error("accepted item did not reach update");

  // a result only comes from a query in its update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_UPDATE && func_q == FUNC_QUERY))
    else $error("result without query");

  // banks are never written while an item is being accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !bank_req[0].wr_en)
    else $error("write overlaps read of a new item");

endmodule

>>> sv/cms_bank.sv
module cms_bank (
  input  logic                clk_i,
  input  cms_pkg::bank_req_t  req_i,
  output cms_pkg::cnt_t       rd_data_o
);
  import cms_pkg::*;

  cnt_t mem_q [Columns];
  cnt_t rd_q;
  cnt_t wr_data;
  logic signed [CntW:0] sum;

  // saturating update of the counter read in the previous cycle, or zero while clearing
  always_comb begin
    sum = {rd_q[CntW-1], rd_q} + {req_i.amount[CntW-1], req_i.amount};
    if (req_i.clear) begin
      wr_data = '0;
    end else if (sum[CntW] != sum[CntW-1]) begin
      wr_data = sum[CntW] ? {1'b1, {(CntW-1){1'b0}}} : {1'b0, {(CntW-1){1'b1}}};
    end else begin
      wr_data = sum[CntW-1:0];
    end
  end

  // counter memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_col];
    end
    if (req_i.wr_en) begin
      mem_q[req_i.wr_col] <= wr_data;
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cms_pkg::*;

  localparam int   WatchdogLimit = 5000;
  localparam int   DrainCycles   = 8;
  localparam int   HoldCycles    = 300;
  localparam int   NumPhases     = 6;
  localparam int   PhaseItems    = 130;
  localparam cnt_t MaxCnt        = 32'sh7FFF_FFFF;
  localparam cnt_t MinCnt        = 32'sh8000_0000;

  // one row of the directed stimulus, with an optional hand-written estimate
  typedef struct packed {
    func_e op;
    key_t  key;
    cnt_t  amount;
    logic  has_est;
    cnt_t  est;
  } stim_row_t;

  // estimate written by hand for an item, if any
  typedef struct packed {
    logic has_est;
    cnt_t est;
  } fixed_est_t;

  logic clk_i;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  cms_in_if  in_if();
  cms_out_if out_if();

  count_min_sketch_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow copy of the sketch and its hash seeds
  cnt_t sketch [Rows][Columns];
  key_t seed [NumSeeds];
  key_t seed_plan [NumSeeds];
  cfg_idx_e seed_reg_idx [NumSeeds] = '{CFG_SEED_ROW0, CFG_SEED_ROW1, CFG_SEED_ROW2,
                                        CFG_SEED_ROW3};

  cnt_t       est_q[$];
  fixed_est_t fixed_q[$];
  stim_row_t  directed_q[$];

  int err_cnt;
  int quiet_cycles;
  bit send_gaps;
  bit recv_stalls;
  bit hold_req;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // shadow update for one item; returns the estimate a query would give
  function automatic cnt_t sketch_step(func_e op, key_t k, cnt_t amt);
    int     r;
    col_t   c;
    longint total;
    cnt_t   best;
    best = MaxCnt;
    for (r = 0; r < Rows; r++) begin
      c = col_t'(k ^ seed[r]);
      if (op == FUNC_ADD) begin
        total = longint'(sketch[r][c]) + longint'(amt);
        if (total > longint'(MaxCnt)) total = longint'(MaxCnt);
        if (total < longint'(MinCnt)) total = longint'(MinCnt);
        sketch[r][c] = cnt_t'(total);
      end else if (sketch[r][c] < best) begin
        best = sketch[r][c];
      end
    end
    return best;
  endfunction

  function automatic key_t rand64();
    return {$urandom(), $urandom()};
  endfunction

  // track accepted items and check returned estimates
  always @(posedge clk_i) begin : scoreboard
    fixed_est_t note;
    cnt_t       guess;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (est_q.size() == 0) begin
          $display("%0t: estimate with none pending, expected none, actual %0d",
                   $time, out_if.estimate);
          err_cnt++;
        end else begin
          guess = est_q.pop_front();
          if (guess !== out_if.estimate) begin
            $display("%0t: estimate mismatch, expected %0d, actual %0d",
                     $time, guess, out_if.estimate);
            err_cnt++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        note  = fixed_q.pop_front();
        guess = sketch_step(func_e'(in_if.func), in_if.key, in_if.amount);
        if (in_if.func == FUNC_QUERY) est_q.push_back(note.has_est ? note.est : guess);
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("[count_min_sketch_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // estimate receiver: random stalls and one long hold-off on request
  initial begin : receiver
    int held;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else if (recv_stalls && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // offer one item and hold it until accepted, then maybe leave a gap
  task automatic drive_item(input func_e op, input key_t k, input cnt_t amt,
                            input logic has_est, input cnt_t est);
    fixed_q.push_back('{has_est, est});
    in_if.valid  <= 1'b1;
    in_if.func   <= op;
    in_if.key    <= k;
    in_if.amount <= amt;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every pending estimate has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (est_q.size() != 0 || fixed_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write all seeds from seed_plan, optionally poking the unused indexes
  task automatic load_seeds(input bit poke_unused);
    int r;
    int u;
    for (r = 0; r < NumSeeds; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= seed_reg_idx[r];
      cfg_data_i <= seed_plan[r];
      seed[r]    = seed_plan[r];
      @(posedge clk_i);
    end
    if (poke_unused) begin
      for (u = 0; u < (1 << CfgIdxW) - NumSeeds; u++) begin
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= CfgIdxW'(NumSeeds + u);
        cfg_data_i <= rand64();
        @(posedge clk_i);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // random item: keys share a few columns so counters pile up and saturate
  task automatic send_random_item();
    func_e op;
    key_t  k;
    cnt_t  amt;
    op = ($urandom_range(0, 99) < 35) ? FUNC_QUERY : FUNC_ADD;
    k  = rand64();
    if ($urandom_range(0, 7) != 0) k[ColW-1:0] = col_t'($urandom_range(0, 15) * 67);
    case ($urandom_range(0, 3))
      0, 1:    amt = cnt_t'(int'($urandom_range(0, 200)) - 100);
      2:       amt = cnt_t'($urandom());
      default: amt = $urandom_range(0, 1) ? MaxCnt - cnt_t'($urandom_range(0, 3))
                                          : MinCnt + cnt_t'($urandom_range(0, 3));
    endcase
    drive_item(op, k, amt, 1'b0, '0);
  endtask

  // main sequence
  initial begin : stimulus
    int p;
    int i;
    int r;
    stim_row_t row;
    err_cnt      = 0;
    quiet_cycles = 0;
    send_gaps    = 1'b0;
    recv_stalls  = 1'b0;
    hold_req     = 1'b0;
    for (r = 0; r < NumSeeds; r++) seed[r] = '0;
    foreach (sketch[a, b]) sketch[a][b] = '0;
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.func    <= FUNC_ADD;
    in_if.key     <= '0;
    in_if.amount  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_SEED_ROW0;
    cfg_data_i    <= '0;

    // directed items with reset seeds: every row hashes a key to its low bits
    directed_q.push_back('{FUNC_QUERY, 64'h0, 32'sd0, 1'b1, 32'sd0});
    directed_q.push_back('{FUNC_QUERY, '1, -32'sd1, 1'b1, 32'sd0});
    directed_q.push_back('{FUNC_ADD, 64'h5, MaxCnt, 1'b0, 32'sd0});
    directed_q.push_back('{FUNC_ADD, 64'hFFFF_FFFF_0000_0005, 32'sd1, 1'b0, 32'sd0});
    directed_q.push_back('{FUNC_QUERY, 64'h5, 32'sd0, 1'b1, MaxCnt});
    directed_q.push_back('{FUNC_ADD, 64'hFFFF_FFFF_FFFF_FC07, MinCnt, 1'b0, 32'sd0});
    directed_q.push_back('{FUNC_ADD, 64'h7, -32'sd1, 1'b0, 32'sd0});
    directed_q.push_back('{FUNC_QUERY, 64'h8000_0000_0000_0007, 32'sd0, 1'b1, MinCnt});
    directed_q.push_back('{FUNC_ADD, 64'h5, MinCnt, 1'b0, 32'sd0});
    directed_q.push_back('{FUNC_QUERY, 64'h5, 32'sd0, 1'b1, -32'sd1});
    directed_q.push_back('{FUNC_ADD, 64'h7, MaxCnt, 1'b0, 32'sd0});
    directed_q.push_back('{FUNC_QUERY, 64'h7, 32'sd0, 1'b1, -32'sd1});
    directed_q.push_back('{FUNC_ADD, 64'h3FF, 32'sd100, 1'b0, 32'sd0});
    directed_q.push_back('{FUNC_QUERY, '1, MaxCnt, 1'b1, 32'sd100});
    directed_q.push_back('{FUNC_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 32'sh5555_5555, 1'b0, 32'sd0});
    directed_q.push_back('{FUNC_ADD, 64'h5555_5555_5555_5555, 32'shAAAA_AAAA, 1'b0, 32'sd0});
    directed_q.push_back('{FUNC_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, MinCnt, 1'b0, 32'sd0});
    directed_q.push_back('{FUNC_QUERY, 64'h5555_5555_5555_5555, 32'sd0, 1'b0, 32'sd0});
    directed_q.push_back('{FUNC_ADD, 64'h8000_0000_0000_0000, -32'sd7, 1'b0, 32'sd0});
    directed_q.push_back('{FUNC_QUERY, 64'h0, 32'sd0, 1'b0, 32'sd0});

    // reset, then wait out the clearing pass through the handshake
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_q[n]) begin
      row = directed_q[n];
      drive_item(row.op, row.key, row.amount, row.has_est, row.est);
    end

    // random phases, each under its own seed setting
    for (p = 0; p < NumPhases; p++) begin
      wait_drained();
      case (p)
        0: for (r = 0; r < NumSeeds; r++) seed_plan[r] = '1;
        2: for (r = 0; r < NumSeeds; r++) seed_plan[r] = '0;
        4: begin
          seed_plan[0] = rand64();
          seed_plan[1] = rand64();
          seed_plan[2] = '1;
          seed_plan[3] = '0;
        end
        default: for (r = 0; r < NumSeeds; r++) seed_plan[r] = rand64();
      endcase
      load_seeds(p == 0);
      send_gaps   = (p == 0 || p == 2 || p == 3 || p == 4);
      recv_stalls = (p == 0 || p == 1 || p == 3 || p == 4);
      for (i = 0; i < PhaseItems; i++) begin
        if (p == 1 && i == 20) hold_req = 1'b1;
        if (p == 2 && i == PhaseItems / 2) wait_drained();
        send_random_item();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && est_q.size() == 0) begin
      $display("[count_min_sketch_core] OK");
    end else begin
      $display("[count_min_sketch_core] ERROR");
    end
    $finish;
  end

endmodule
